// ===== rtl/efphr_pkg.sv =====
// Shared constants and types for the ECG filter, peak and heart-rate block.
// No dependencies; imported by ecg_filter_peak_heart_rate.
`timescale 1ns / 1ps
`default_nettype none

package efphr_pkg;

    // Default datapath widths
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH_DEF  = 24;

    // Fixed field and register widths
    localparam int ALPHA_W  = 9;
    localparam int THRESH_W = 16;
    localparam int RATE_W   = 16;
    localparam int CFG_DW   = 16;
    localparam int CFG_IW   = 1;
    localparam int SCALE_W  = 16;   // holds the 60000 beats-per-minute scale

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ALPHA  = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_THRESH = 1'd1;

    // Reset values and arithmetic constants
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
    localparam logic [SCALE_W-1:0] RATE_SCALE  = 16'd60000;
    localparam logic [RATE_W-1:0]  RATE_MAX    = 16'hFFFF;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_PEAK = 8'b0000_1000,
        ST_NUM  = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_FIN  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/ecg_filter_peak_heart_rate.sv =====
// ECG low-pass filter, local-maximum peak detector and heart-rate estimator.
// Depends on efphr_pkg for widths, register indexes and the sequencer states.
//
//   channel | dir | handshake           | payload
//   s_      | in  | s_tvalid / s_tready | tdata: amplitude, time_ms; tuser: start_req
//   m_      | out | m_tvalid / m_tready | tdata: filtered, peak_time_ms, peak_count,
//           |     |                     |        heart_rate_bpm; tuser: peak_found
//   cfg_    | in  | cfg_wr_en           | cfg_wr_index, cfg_wr_data
//
// A sample without a new peak passes the multiply, accumulate and peak-test steps to the
// output register; a peak adds the numerator step, and a peak with a defined rate also
// runs the one-bit-per-cycle restoring divider and a final step that form the heart rate.
// s_tready rises the cycle after the output load.
// One shared multiplier does both filter products and the rate numerator.
// Reset (aresetn low, synchronous) clears the record and sets alpha 128, threshold 0.
// A held output beat stalls the sequencer in its last step; s_tready is high only idle.
`timescale 1ns / 1ps
`default_nettype none

module ecg_filter_peak_heart_rate #(
    parameter int SAMPLE_WIDTH = efphr_pkg::SAMPLE_WIDTH_DEF,
    parameter int TIME_WIDTH   = efphr_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH  = efphr_pkg::COUNT_WIDTH_DEF,
    parameter int S_DW = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8,
    parameter int M_DW = ((SAMPLE_WIDTH + TIME_WIDTH + COUNT_WIDTH
                          + efphr_pkg::RATE_W + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input samples
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [S_DW-1:0]                s_tdata,  // amplitude, time_ms, zero pad
    input  wire logic [0:0]                     s_tuser,  // start_req
    // results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [M_DW-1:0]                     m_tdata,  // filtered, peak_time_ms,
                                                          // peak_count, heart_rate_bpm, pad
    output logic [0:0]                          m_tuser,  // peak_found
    // configuration writes
    input  wire logic                           cfg_wr_en,
    input  wire logic [efphr_pkg::CFG_IW-1:0]   cfg_wr_index,
    input  wire logic [efphr_pkg::CFG_DW-1:0]   cfg_wr_data
);
    import efphr_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int TW   = TIME_WIDTH;
    localparam int CW   = COUNT_WIDTH;
    localparam int MBW  = ((SW > CW) ? SW : CW) + 1;     // shared multiplier operand B
    localparam int MAW  = SCALE_W + 1;                   // shared multiplier operand A
    localparam int PW   = MAW + MBW;                     // product and accumulator
    localparam int NUMW = SCALE_W + CW;                  // rate numerator
    localparam int DCW  = $clog2(NUMW + 1);
    localparam int CMPW = (SW > THRESH_W) ? SW : THRESH_W;

    // configuration registers
    logic [ALPHA_W-1:0]         alpha_reg;
    logic signed [THRESH_W-1:0] thresh_reg;

    // sequencer and item registers
    seq_state_t                 state_reg, state_next;
    logic signed [SW-1:0]       x_reg;
    logic [TW-1:0]              t_reg;
    logic signed [PW-1:0]       acc_reg;
    logic signed [SW-1:0]       y_reg;
    logic                       pk_reg;
    logic [TW-1:0]              pk_time_reg;

    // record state
    logic signed [SW-1:0]       last_filt_reg;
    logic signed [SW-1:0]       older_filt_reg;
    logic [TW-1:0]              last_time_reg;
    logic [1:0]                 seen_reg;
    logic [TW-1:0]              first_pk_reg;
    logic [TW-1:0]              latest_pk_reg;
    logic [CW-1:0]              cnt_reg;
    logic [RATE_W-1:0]          rate_reg;

    // divider registers
    logic [NUMW-1:0]            dvd_reg;
    logic [TW-1:0]              rem_reg;
    logic [TW-1:0]              span_reg;
    logic [DCW-1:0]             div_cnt_reg;

    // output registers
    logic                       out_valid_reg;
    logic signed [SW-1:0]       out_filt_reg;
    logic                       out_pk_reg;
    logic [TW-1:0]              out_ptime_reg;
    logic [CW-1:0]              out_cnt_reg;
    logic [RATE_W-1:0]          out_rate_reg;

    logic                       s_fire;
    logic                       out_load;
    logic [ALPHA_W-1:0]         alpha_sat;
    logic signed [MAW-1:0]      op_a;
    logic signed [MBW-1:0]      op_b;
    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       sum;
    logic signed [PW-1:0]       y_wide;
    logic                       y_in_range;
    logic signed [SW-1:0]       y_sat;
    logic signed [CMPW-1:0]     last_cmp;
    logic signed [CMPW-1:0]     thresh_cmp;
    logic                       is_peak;
    logic [CW-1:0]              cnt_m1;
    logic                       rate_defined;
    logic [TW:0]                trial;
    logic [TW:0]                diff;
    logic                       q_bit;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // Configuration registers: the user must write them only while idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RESET;
            thresh_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ALPHA:  alpha_reg  <= cfg_wr_data[ALPHA_W-1:0];
                CFG_THRESH: thresh_reg <= $signed(cfg_wr_data[THRESH_W-1:0]);
                default:    ;
            endcase
        end
    end

    // Shared multiplier: alpha*x, then (1-alpha)*y_prev, then scale*(count-1)
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign cnt_m1    = cnt_reg - CW'(1);

    always_comb begin
        case (state_reg)
            ST_ACC: begin
                op_a = $signed(MAW'(ALPHA_ONE - alpha_sat));
                op_b = MBW'(last_filt_reg);
            end
            ST_NUM: begin
                op_a = $signed(MAW'(RATE_SCALE));
                op_b = $signed({1'b0, (MBW-1)'(cnt_m1)});
            end
            default: begin
                op_a = $signed(MAW'(alpha_sat));
                op_b = MBW'(x_reg);
            end
        endcase
    end

    assign prod = op_a * op_b;

    // Filter rounding, arithmetic shift and clamp
    assign sum        = acc_reg + prod + PW'(128);
    assign y_wide     = sum >>> 8;
    assign y_in_range = (&y_wide[PW-1:SW-1]) || !(|y_wide[PW-1:SW-1]);
    assign y_sat      = y_in_range ? y_wide[SW-1:0]
                      : (y_wide[PW-1] ? $signed({1'b1, {(SW-1){1'b0}}})
                                      : $signed({1'b0, {(SW-1){1'b1}}}));

    // Peak test on the previous filtered sample
    assign last_cmp   = CMPW'(last_filt_reg);
    assign thresh_cmp = CMPW'(thresh_reg);
    assign is_peak    = (seen_reg >= 2'd2) && (last_filt_reg > older_filt_reg)
                     && (last_filt_reg > y_reg) && (last_cmp > thresh_cmp);

    assign rate_defined = (cnt_reg >= CW'(2)) && (latest_pk_reg > first_pk_reg);

    // Restoring divider step
    assign trial = {rem_reg, dvd_reg[NUMW-1]};
    assign diff  = trial - {1'b0, span_reg};
    assign q_bit = !diff[TW];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_PEAK;
            ST_PEAK: state_next = is_peak ? ST_NUM : ST_OUT;
            ST_NUM:  state_next = rate_defined ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_cnt_reg == DCW'(1)) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Record state: clear on reset or start beat, update after the peak test
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_filt_reg  <= '0;
            older_filt_reg <= '0;
            last_time_reg  <= '0;
            seen_reg       <= '0;
            first_pk_reg   <= '0;
            latest_pk_reg  <= '0;
            cnt_reg        <= '0;
            rate_reg       <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_tuser[0]) begin
                        last_filt_reg  <= '0;
                        older_filt_reg <= '0;
                        last_time_reg  <= '0;
                        seen_reg       <= '0;
                        first_pk_reg   <= '0;
                        latest_pk_reg  <= '0;
                        cnt_reg        <= '0;
                        rate_reg       <= '0;
                    end
                end
                ST_PEAK: begin
                    older_filt_reg <= last_filt_reg;
                    last_filt_reg  <= y_reg;
                    last_time_reg  <= t_reg;
                    if (seen_reg < 2'd2) begin
                        seen_reg <= seen_reg + 2'd1;
                    end
                    if (is_peak) begin
                        if (cnt_reg == '0) begin
                            first_pk_reg <= last_time_reg;
                        end
                        latest_pk_reg <= last_time_reg;
                        if (cnt_reg != {CW{1'b1}}) begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                end
                ST_NUM: begin
                    if (!rate_defined) begin
                        rate_reg <= '0;
                    end
                end
                ST_FIN: begin
                    rate_reg <= (|dvd_reg[NUMW-1:RATE_W]) ? RATE_MAX : dvd_reg[RATE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Item datapath: capture, filter, peak flag, divider
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    x_reg <= $signed(s_tdata[SW-1:0]);
                    t_reg <= s_tdata[SW+TW-1:SW];
                end
            end
            ST_MUL: acc_reg <= prod;
            ST_ACC: y_reg <= (seen_reg == 2'd0) ? x_reg : y_sat;
            ST_PEAK: begin
                pk_reg      <= is_peak;
                pk_time_reg <= is_peak ? last_time_reg : '0;
            end
            ST_NUM: begin
                dvd_reg     <= prod[NUMW-1:0];
                rem_reg     <= '0;
                span_reg    <= latest_pk_reg - first_pk_reg;
                div_cnt_reg <= DCW'(NUMW);
            end
            ST_DIV: begin
                if (q_bit) begin
                    rem_reg <= diff[TW-1:0];
                end else begin
                    rem_reg <= trial[TW-1:0];
                end
                dvd_reg     <= {dvd_reg[NUMW-2:0], q_bit};
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
            default: ;
        endcase
    end

    // Output register: load the finished beat, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_filt_reg  <= y_reg;
            out_pk_reg    <= pk_reg;
            out_ptime_reg <= pk_time_reg;
            out_cnt_reg   <= cnt_reg;
            out_rate_reg  <= rate_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pk_reg;
    assign m_tdata  = M_DW'({out_rate_reg, out_cnt_reg, out_ptime_reg, out_filt_reg});

`ifndef SYNTHESIS
    // A new result beat only appears from the output step
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result beat raised outside the output step");

    // A reported peak has been counted
    a_peak_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (out_cnt_reg != '0))
        else $error("peak reported with zero peak count");

    // A nonzero rate needs at least two peaks
    a_rate_two_peaks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_rate_reg != '0)) |-> (out_cnt_reg >= CW'(2)))
        else $error("heart rate reported with fewer than two peaks");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== test/efphr_checker.sv =====
// Result checker for the ECG filter, peak and heart-rate block: snoops the sample,
// result and register-write channels, predicts each result and compares it field by field.
// Depends on efphr_pkg for widths, register indexes and arithmetic constants.
`timescale 1ns / 1ps

module efphr_checker #(
    parameter int SW   = efphr_pkg::SAMPLE_WIDTH_DEF,
    parameter int TW   = efphr_pkg::TIME_WIDTH_DEF,
    parameter int CW   = efphr_pkg::COUNT_WIDTH_DEF,
    parameter int S_DW = ((SW + TW + 7) / 8) * 8,
    parameter int M_DW = ((SW + TW + CW + efphr_pkg::RATE_W + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [S_DW-1:0]              s_tdata,   // amplitude, time_ms, zero pad
    input  wire logic [0:0]                   s_tuser,   // start_req
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [M_DW-1:0]              m_tdata,   // filtered, peak_time_ms,
                                                         // peak_count, heart_rate_bpm, pad
    input  wire logic [0:0]                   m_tuser,   // peak_found
    input  wire logic                         cfg_wr_en,
    input  wire logic [efphr_pkg::CFG_IW-1:0] cfg_wr_index,
    input  wire logic [efphr_pkg::CFG_DW-1:0] cfg_wr_data,
    output int                                fail_count,
    output int                                outstanding,
    output int                                results_checked,
    output int                                peaks_checked,
    output int                                rates_saturated
);
    import efphr_pkg::*;

    localparam longint SAMPLE_HI = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
    localparam int     REPORT_CAP = 100;

    typedef struct packed {
        logic [SW-1:0]     filtered;
        logic              peak_found;
        logic [TW-1:0]     peak_time;
        logic [CW-1:0]     peak_count;
        logic [RATE_W-1:0] bpm;
    } ecg_result_t;

    // register copies
    logic [ALPHA_W-1:0]         alpha_q8;
    logic signed [THRESH_W-1:0] threshold;

    // record state of the predicted block
    logic signed [SW-1:0] last_y;
    logic signed [SW-1:0] older_y;
    logic [TW-1:0]        last_stamp;
    logic [1:0]           samples_seen;
    logic [TW-1:0]        first_peak;
    logic [TW-1:0]        latest_peak;
    logic [CW-1:0]        peak_total;
    logic [RATE_W-1:0]    bpm_now;

    ecg_result_t pending_results[$];

    function automatic void clear_record();
        last_y       = '0;
        older_y      = '0;
        last_stamp   = '0;
        samples_seen = '0;
        first_peak   = '0;
        latest_peak  = '0;
        peak_total   = '0;
        bpm_now      = '0;
    endfunction

    // Filter one sample, test the previous one for a peak, update count and rate
    function automatic ecg_result_t predict_sample(input logic start,
                                                   input logic [SW-1:0] amp_bits,
                                                   input logic [TW-1:0] stamp);
        ecg_result_t res;
        longint      x;
        longint      y;
        longint      w;
        longint      span;
        longint      q;
        res = '0;
        if (start) clear_record();
        x = longint'($signed(amp_bits));
        // first sample of a record passes straight through
        if (samples_seen == 0) begin
            y = x;
        end else begin
            w = (alpha_q8 > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_q8);
            y = (w * x + (longint'(ALPHA_ONE) - w) * longint'(last_y) + 128) >>> 8;
            if (y > SAMPLE_HI) y = SAMPLE_HI;
            if (y < SAMPLE_LO) y = SAMPLE_LO;
        end
        // previous sample is a peak if above both neighbors and the threshold
        if (samples_seen >= 2 && longint'(last_y) > longint'(older_y) &&
            longint'(last_y) > y && longint'(last_y) > longint'(threshold)) begin
            res.peak_found = 1'b1;
            res.peak_time  = last_stamp;
            if (peak_total == 0) first_peak = last_stamp;
            latest_peak = last_stamp;
            if (peak_total != '1) peak_total = peak_total + 1'b1;
            // rate is undefined below two peaks or for a non-positive span
            if (peak_total < 2 || latest_peak <= first_peak) begin
                bpm_now = '0;
            end else begin
                span = longint'(latest_peak - first_peak);
                q    = longint'(RATE_SCALE) * (longint'(peak_total) - 1) / span;
                bpm_now = (q > longint'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
            end
        end
        older_y    = last_y;
        last_y     = y[SW-1:0];
        last_stamp = stamp;
        if (samples_seen < 2) samples_seen = samples_seen + 1'b1;
        res.filtered   = y[SW-1:0];
        res.peak_count = peak_total;
        res.bpm        = bpm_now;
        return res;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got) begin
            if (fail_count < REPORT_CAP)
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // Snoop all three channels on every rising edge
    always @(posedge aclk) begin : snoop
        ecg_result_t want;
        if (!aresetn) begin
            alpha_q8  = ALPHA_RESET;
            threshold = '0;
            clear_record();
            pending_results.delete();
        end else begin
            // compare a result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    if (fail_count < REPORT_CAP)
                        $error("result beat arrived with no sample waiting for it");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("filtered", longint'($signed(want.filtered)),
                                longint'($signed(m_tdata[SW-1:0])));
                    check_field("peak_found", want.peak_found, m_tuser[0]);
                    check_field("peak_time_ms", want.peak_time, m_tdata[SW +: TW]);
                    check_field("peak_count", want.peak_count, m_tdata[SW+TW +: CW]);
                    check_field("heart_rate_bpm", want.bpm,
                                m_tdata[SW+TW+CW +: RATE_W]);
                    results_checked++;
                    if (want.peak_found) peaks_checked++;
                    if (want.bpm == RATE_MAX) rates_saturated++;
                end
            end
            // track register writes
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_ALPHA:  alpha_q8  = cfg_wr_data[ALPHA_W-1:0];
                    CFG_THRESH: threshold = cfg_wr_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            // predict the result of an accepted sample beat
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(),
                                       predict_sample(s_tuser[0], s_tdata[SW-1:0],
                                                      s_tdata[SW +: TW]));
        end
        outstanding <= pending_results.size();
    end

endmodule

// ===== test/tb_ecg_filter_peak_heart_rate.sv =====
// Testbench top for ecg_filter_peak_heart_rate: drives samples and register writes,
// throttles the result channel and reports the verdict.
// Depends on efphr_pkg, the block itself and efphr_checker.
`timescale 1ns / 1ps

module tb_ecg_filter_peak_heart_rate;
    import efphr_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int TW          = TIME_WIDTH_DEF;
    localparam int CW          = COUNT_WIDTH_DEF;
    localparam int S_DW        = ((SW + TW + 7) / 8) * 8;
    localparam int M_DW        = ((SW + TW + CW + RATE_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SAMPLE_HI    = (1 << (SW - 1)) - 1;
    localparam int SAMPLE_LO    = -SAMPLE_HI - 1;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [S_DW-1:0]   s_tdata;   // amplitude, time_ms, zero pad
    logic [0:0]        s_tuser;   // start_req
    logic              m_tvalid;
    logic              m_tready;
    logic [M_DW-1:0]   m_tdata;   // filtered, peak_time_ms, peak_count, heart_rate_bpm, pad
    logic [0:0]        m_tuser;   // peak_found
    logic              cfg_wr_en;
    logic [CFG_IW-1:0] cfg_wr_index;
    logic [CFG_DW-1:0] cfg_wr_data;

    int fail_count;
    int outstanding;
    int results_checked;
    int peaks_checked;
    int rates_saturated;

    int samples_sent;
    int burst_left;
    int phases;
    int cycle_count;

    ecg_filter_peak_heart_rate u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    efphr_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .peaks_checked   (peaks_checked),
        .rates_saturated (rates_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: stall on a changing pattern, with long hold-offs now and then
    initial begin : result_sink
        int            beats;
        int            hold_left;
        int            hold_mark;
        int            tick;
        logic [15:0]   ready_pattern;
        beats         = 0;
        hold_left     = 0;
        hold_mark     = 400;
        tick          = 0;
        ready_pattern = '1;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) beats++;
            if (tick % 128 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    ready_pattern = '1;
                    2:       ready_pattern = 16'($urandom) | 16'h0001;
                    3:       ready_pattern = 16'hAAAA;
                    default: ready_pattern = 16'h0F0F;
                endcase
            end
            // hold off long enough that the block fills and drops s_tready
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (beats >= hold_mark) begin
                m_tready <= 1'b0;
                hold_left = 299;
                hold_mark += 800;
            end else begin
                m_tready <= ready_pattern[tick % 16];
            end
            tick++;
        end
    end

    // Offer one sample beat; bursts of random length with random gaps between them
    task automatic send_sample(input logic start, input logic [SW-1:0] amp,
                               input logic [TW-1:0] stamp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= S_DW'({stamp, amp});
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        samples_sent++;
    endtask

    // Drain the block, then write both registers
    task automatic retune(input logic [CFG_DW-1:0] alpha_word,
                          input logic [CFG_DW-1:0] level);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_ALPHA;
        cfg_wr_data  <= alpha_word;
        @(posedge aclk);
        cfg_wr_index <= CFG_THRESH;
        cfg_wr_data  <= level;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        phases++;
    endtask

    // One record: noisy baseline with periodic spikes, a few corrupted beats mixed in
    task automatic send_record(input int len);
        int            period;
        int            step;
        int            base;
        int            spike;
        int            noise;
        int            level;
        int            i;
        logic [TW-1:0] stamp;
        logic [TW-1:0] when;
        logic          start;
        period = $urandom_range(3, 20);
        step   = $urandom_range(1, 8);
        base   = int'($urandom_range(0, 4000)) - 2000;
        spike  = int'($urandom_range(1000, 30000));
        noise  = int'($urandom_range(0, 400));
        stamp  = ($urandom_range(0, 3) == 0) ? TW'($urandom) : TW'($urandom_range(0, 100000));
        for (i = 0; i < len; i++) begin
            start = (i == 0);
            when  = stamp;
            level = base + int'($urandom_range(0, 2 * noise)) - noise;
            if (i % period == 0) level += spike;
            // stray amplitude, stray timestamp or stray record start
            if ($urandom_range(0, 99) < 6) begin
                level = int'($urandom_range(0, 65535)) + SAMPLE_LO;
                if ($urandom_range(0, 1) == 1) when = TW'($urandom);
                if ($urandom_range(0, 3) == 0) start = 1'b1;
            end
            if (level > SAMPLE_HI) level = SAMPLE_HI;
            if (level < SAMPLE_LO) level = SAMPLE_LO;
            send_sample(start, level[SW-1:0], when);
            stamp += TW'(step);
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        logic [CFG_DW-1:0] alpha_word;
        logic [CFG_DW-1:0] level;
        int                random_goal;
        int                phase_end;
        samples_sent = 0;
        burst_left   = 0;
        phases       = 0;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= CFG_ALPHA;
        cfg_wr_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // alpha above one saturates, so the filter passes samples through
        retune(16'h01FF, 16'h8000);
        send_sample(1'b1, 16'sh8000, 32'd10);   // first sample passes unchanged
        send_sample(1'b0, 16'sh7FFF, 32'd11);   // two samples: no peak test yet
        send_sample(1'b0, 16'sh8000, 32'd12);   // peak at 11, single peak: rate 0
        send_sample(1'b0, 16'sh7FFF, 32'd12);
        send_sample(1'b0, 16'sd0,    32'd13);   // second peak, span 1
        send_sample(1'b0, 16'sd100,  32'd12);
        send_sample(1'b0, -16'sd5,   32'd15);   // three peaks in 1 ms: rate saturates
        send_sample(1'b0, 16'sd200,  32'd5);    // timestamp goes backward
        send_sample(1'b0, -16'sd1,   32'd6);    // latest peak before first: rate 0
        send_sample(1'b1, 16'sd1234, 32'hFFFF_FFFF);  // restart mid-stream
        send_sample(1'b0, 16'sd2000, 32'd0);
        send_sample(1'b0, 16'sd0,    32'd1);
        send_sample(1'b0, 16'sd3000, 32'd2);
        send_sample(1'b0, 16'sd0,    32'd3);

        // alpha zero freezes the filter, and nothing beats the top threshold
        retune(16'h0000, 16'h7FFF);
        send_sample(1'b1, 16'sh7FFF, 32'd100);
        send_sample(1'b0, 16'sh8000, 32'd101);
        send_sample(1'b0, 16'sh8000, 32'd102);

        // smallest nonzero alpha, written with unused upper data bits set
        retune(16'hFE01, 16'h0000);
        send_sample(1'b1, 16'sh8000, 32'd0);
        send_sample(1'b0, 16'sh7FFF, 32'd1);
        send_sample(1'b0, 16'sh8000, 32'd2);
        send_sample(1'b0, 16'sh7FFF, 32'd3);

        // random phases: new register settings, then a run of records
        random_goal = samples_sent + RANDOM_ITEMS;
        while (samples_sent < random_goal) begin
            case ($urandom_range(0, 5))
                0:       alpha_word = 16'd0;
                1:       alpha_word = CFG_DW'(ALPHA_ONE);
                2:       alpha_word = CFG_DW'($urandom_range(257, 511));
                default: alpha_word = CFG_DW'($urandom_range(1, 255));
            endcase
            if ($urandom_range(0, 3) == 0) alpha_word[15:9] = 7'($urandom);
            case ($urandom_range(0, 7))
                0:       level = 16'h8000;
                1:       level = 16'h7FFF;
                2:       level = 16'($urandom);
                default: level = 16'($urandom_range(0, 3000) - 1500);
            endcase
            retune(alpha_word, level);
            phase_end = samples_sent + $urandom_range(80, 200);
            while (samples_sent < phase_end) send_record($urandom_range(4, 60));
        end

        // wait for the last results, then keep clocking to catch strays
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples over %0d register settings; checked %0d results, %0d peaks.",
                 samples_sent, phases, results_checked, peaks_checked);
        $display("Heart rate at saturation on %0d results.", rates_saturated);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
